@@ sv/beacon_address_registry_unit_assert.svh @@
// Assertion macros used by the registry checker.
`ifndef BEACON_ADDRESS_REGISTRY_UNIT_ASSERT_SVH
`define BEACON_ADDRESS_REGISTRY_UNIT_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define BAR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge while reset is held.
`define BAR_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) !rst_n |-> (prop)) else $error(msg);

`endif

@@ sv/bar_pkg.sv @@
package bar_pkg;

	localparam int ENTRY_COUNT = 16;

	typedef enum logic [1:0] {
		OP_SIGHT = 2'd0,
		OP_FIND  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [47:0]        address;
		logic [15:0]        environment;
		logic [15:0]        device;
		logic signed [7:0]  strength;
		logic [31:0]        first_seen;
		logic [31:0]        last_seen;
		logic [31:0]        sightings;
	} entry_t;

	typedef struct packed {
		op_t                operation;
		logic [47:0]        beacon_address;
		logic [15:0]        environment_tag;
		logic [15:0]        device_tag;
		logic signed [7:0]  signal_strength;
		logic [31:0]        now_ms;
		logic [3:0]         slot_index;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic        inserted;
		logic [4:0]  new_count;
		logic        entry_new;
		entry_t      entry;
	} result_t;

endpackage

@@ sv/beacon_address_registry_unit.sv @@
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   operation, beacon_address, environment_tag,
//                                            device_tag, signal_strength, now_ms, slot_index
// out       output     out_valid / out_ready hit, slot, inserted, new_count, entry_*
//
// Sighting and find read and compare one entry a cycle from the entry memory, stopping
// at the first used match; clear and read go straight to the commit step.
// One transaction is in flight at a time, so reads never overlap the write-back.
// Reset clears the used and new flags and the new count at once; no clearing pass.
// A finished result waits in the output register while the next transaction is
// accepted; that transaction holds in its commit step until the register is taken.
module beacon_address_registry_unit #(
	parameter int ENTRIES = bar_pkg::ENTRY_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [47:0]        beacon_address,
	input  logic [15:0]        environment_tag,
	input  logic [15:0]        device_tag,
	input  logic signed [7:0]  signal_strength,
	input  logic [31:0]        now_ms,
	input  logic [3:0]         slot_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [3:0]         slot,
	output logic               inserted,
	output logic [4:0]         new_count,
	output logic               entry_new,
	output logic [47:0]        entry_address,
	output logic [15:0]        entry_environment,
	output logic [15:0]        entry_device,
	output logic signed [7:0]  entry_strength,
	output logic [31:0]        entry_first_seen,
	output logic [31:0]        entry_last_seen,
	output logic [31:0]        entry_sightings
);
	import bar_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	req_t          req;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;
	logic          res_valid;
	logic          res_ready;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	assign req = '{
		operation:       op_t'(operation),
		beacon_address:  beacon_address,
		environment_tag: environment_tag,
		device_tag:      device_tag,
		signal_strength: signal_strength,
		now_ms:          now_ms,
		slot_index:      slot_index
	};

	assign res_ready = !out_valid_q || out_ready;

	bar_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	bar_entry_ram #(.ENTRIES(ENTRIES)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign hit               = out_q.hit;
	assign slot              = out_q.slot;
	assign inserted          = out_q.inserted;
	assign new_count         = out_q.new_count;
	assign entry_new         = out_q.entry_new;
	assign entry_address     = out_q.entry.address;
	assign entry_environment = out_q.entry.environment;
	assign entry_device      = out_q.entry.device;
	assign entry_strength    = out_q.entry.strength;
	assign entry_first_seen  = out_q.entry.first_seen;
	assign entry_last_seen   = out_q.entry.last_seen;
	assign entry_sightings   = out_q.entry.sightings;

endmodule

@@ sv/bar_entry_ram.sv @@
module bar_entry_ram #(
	parameter int ENTRIES = bar_pkg::ENTRY_COUNT,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output bar_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  bar_pkg::entry_t wr_data
);
	import bar_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold the read data until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/bar_ctrl.sv @@
module bar_ctrl #(
	parameter int ENTRIES = bar_pkg::ENTRY_COUNT,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bar_pkg::req_t      req,
	output logic               res_valid,
	input  logic               res_ready,
	output bar_pkg::result_t   res,
	output logic               rd_en,
	output logic [IW-1:0]      rd_addr,
	input  bar_pkg::entry_t    rd_data,
	output logic               wr_en,
	output logic [IW-1:0]      wr_addr,
	output bar_pkg::entry_t    wr_data
);
	import bar_pkg::*;

	state_t             state_q, state_d;
	req_t               req_q;
	logic               in_range_q;
	logic [IW:0]        scan_q;
	logic [IW-1:0]      rd_idx_s1;
	logic               rd_vld_s1;
	logic               found_q;
	logic [IW-1:0]      found_idx_q;
	logic               free_found_q;
	logic [IW-1:0]      free_idx_q;
	logic [ENTRIES-1:0] used_q, used_d;
	logic [ENTRIES-1:0] new_q, new_d;
	logic [4:0]         new_total_q, new_total_d;

	logic               accept;
	logic               scan_op;
	logic               in_range_now;
	logic               match_now;
	logic               scan_end;
	logic               scan_more;
	logic               free_now;
	logic               commit;
	logic [IW-1:0]      idx_w;

	assign accept       = in_valid && in_ready;
	assign scan_op      = (req.operation == OP_SIGHT) || (req.operation == OP_FIND);
	assign in_range_now = int'(req.slot_index) < ENTRIES;
	assign match_now    = (state_q == ST_SCAN) && rd_vld_s1 && used_q[rd_idx_s1]
		&& (rd_data.address == req_q.beacon_address);
	assign scan_end     = (state_q == ST_SCAN) && rd_vld_s1
		&& (rd_idx_s1 == IW'(ENTRIES - 1));
	assign scan_more    = scan_q < (IW + 1)'(ENTRIES);
	assign free_now     = rd_vld_s1 && !used_q[rd_idx_s1] && !free_found_q;
	assign commit       = (state_q == ST_COMMIT) && res_ready;
	assign idx_w        = IW'(req_q.slot_index);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = scan_op ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (match_now || scan_end) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		rd_en       = 1'b0;
		rd_addr     = scan_q[IW-1:0];
		wr_en       = 1'b0;
		wr_addr     = found_idx_q;
		wr_data     = rd_data;
		used_d      = used_q;
		new_d       = new_q;
		new_total_d = new_total_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && !scan_op && in_range_now) begin
					rd_en   = 1'b1;
					rd_addr = IW'(req.slot_index);
				end
			end
			ST_SCAN: begin
				// Stop reading on a match so the matched entry stays on the read port.
				rd_en = scan_more && !match_now;
			end
			ST_COMMIT: begin
				res_valid = 1'b1;
				case (req_q.operation)
					OP_SIGHT: begin
						if (found_q) begin
							res.hit                = 1'b1;
							res.slot               = 4'(found_idx_q);
							wr_en                  = res_ready;
							wr_addr                = found_idx_q;
							wr_data.last_seen      = req_q.now_ms;
							wr_data.strength       = req_q.signal_strength;
							wr_data.sightings      = rd_data.sightings + 32'd1;
						end else if (free_found_q) begin
							res.slot     = 4'(free_idx_q);
							res.inserted = 1'b1;
							wr_en        = res_ready;
							wr_addr      = free_idx_q;
							wr_data      = '{
								address:     req_q.beacon_address,
								environment: req_q.environment_tag,
								device:      req_q.device_tag,
								strength:    req_q.signal_strength,
								first_seen:  req_q.now_ms,
								last_seen:   req_q.now_ms,
								sightings:   32'd1
							};
							used_d[free_idx_q] = 1'b1;
							new_d[free_idx_q]  = 1'b1;
							new_total_d        = new_total_q + 5'd1;
						end
					end
					OP_FIND: begin
						if (found_q) begin
							res.hit  = 1'b1;
							res.slot = 4'(found_idx_q);
						end
					end
					OP_CLEAR: begin
						if (in_range_q) begin
							res.slot = req_q.slot_index;
							if (used_q[idx_w]) begin
								res.hit = 1'b1;
								if (new_q[idx_w]) begin
									new_d[idx_w] = 1'b0;
									new_total_d  = new_total_q - 5'd1;
								end
							end
						end
					end
					OP_READ: begin
						if (in_range_q) begin
							res.hit       = used_q[idx_w];
							res.slot      = req_q.slot_index;
							res.entry_new = new_q[idx_w];
							// An unused slot was never written: report it as cleared.
							if (used_q[idx_w]) begin
								res.entry = rd_data;
							end
						end
					end
					default: ;
				endcase
				res.new_count = new_total_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			used_q       <= '0;
			new_q        <= '0;
			new_total_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_q       <= '0;
				rd_vld_s1    <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (rd_en) begin
					scan_q <= scan_q + (IW + 1)'(1);
				end
				rd_vld_s1 <= rd_en;
				if (match_now) begin
					found_q <= 1'b1;
				end
				if (free_now) begin
					free_found_q <= 1'b1;
				end
			end
			if (commit) begin
				used_q      <= used_d;
				new_q       <= new_d;
				new_total_q <= new_total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			in_range_q <= in_range_now;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_s1 <= scan_q[IW-1:0];
			if (match_now) begin
				found_idx_q <= rd_idx_s1;
			end
			if (free_now) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

endmodule

@@ sv/bar_checker.sv @@
`include "beacon_address_registry_unit_assert.svh"

module bar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       hit,
	input logic [3:0] slot,
	input logic       inserted,
	input logic [4:0] new_count,
	input logic       entry_new
);

	`BAR_ASSERT_IN_RESET(a_no_result_in_reset, clk, arst_n, !out_valid, "result shown in reset")

	`BAR_ASSERT(a_result_holds, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot) && $stable(new_count), "stalled result changed")

	// One transaction at a time: the input closes right after an accept.
	`BAR_ASSERT(a_one_in_flight, clk, arst_n, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")

	`BAR_ASSERT(a_insert_not_hit, clk, arst_n, out_valid |-> !(inserted && hit), "insert reported as hit")

	`BAR_ASSERT(a_new_implies_used, clk, arst_n, out_valid && entry_new |-> hit, "new mark on an unused slot")

endmodule

bind beacon_address_registry_unit bar_checker u_bar_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import bar_pkg::*;

	localparam int RANDOM_ITEMS = 920;
	localparam int CALM_ITEMS   = 150;
	localparam int DRAIN_CYCLES = 2 * ENTRY_COUNT + 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		req_t    req;
		bit      typed;
		result_t want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic [47:0]        beacon_address;
	logic [15:0]        environment_tag;
	logic [15:0]        device_tag;
	logic signed [7:0]  signal_strength;
	logic [31:0]        now_ms;
	logic [3:0]         slot_index;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic [3:0]         slot;
	logic               inserted;
	logic [4:0]         new_count;
	logic               entry_new;
	logic [47:0]        entry_address;
	logic [15:0]        entry_environment;
	logic [15:0]        entry_device;
	logic signed [7:0]  entry_strength;
	logic [31:0]        entry_first_seen;
	logic [31:0]        entry_last_seen;
	logic [31:0]        entry_sightings;

	// Shadow copy of the beacon table
	entry_t      beacon_entry [ENTRY_COUNT];
	bit          beacon_used  [ENTRY_COUNT];
	bit          beacon_new   [ENTRY_COUNT];
	logic [4:0]  beacon_new_total;

	result_t     expected_q[$];
	script_row_t script[$];
	int          mismatch_count = 0;
	int          cycle_count;
	int          send_idle_pct = 0;
	bit          calm = 1'b0;

	always #2 clk = ~clk;

	beacon_address_registry_unit #(.ENTRIES(ENTRY_COUNT)) dut (.*);

	function automatic result_t registry_outcome(req_t r);
		result_t res;
		int      hit_at;
		int      free_at;
		res = '0;
		hit_at = -1;
		free_at = -1;
		// scan downward so the lowest match and lowest free slot win
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if (beacon_used[i] && beacon_entry[i].address == r.beacon_address)
				hit_at = i;
			if (!beacon_used[i])
				free_at = i;
		end
		case (r.operation)
			OP_SIGHT: begin
				if (hit_at >= 0) begin
					beacon_entry[hit_at].last_seen = r.now_ms;
					beacon_entry[hit_at].strength  = r.signal_strength;
					beacon_entry[hit_at].sightings = beacon_entry[hit_at].sightings + 32'd1;
					res.hit  = 1'b1;
					res.slot = 4'(hit_at);
				end else if (free_at >= 0) begin
					beacon_used[free_at]  = 1'b1;
					beacon_new[free_at]   = 1'b1;
					beacon_entry[free_at] = '{address: r.beacon_address,
						environment: r.environment_tag, device: r.device_tag,
						strength: r.signal_strength, first_seen: r.now_ms,
						last_seen: r.now_ms, sightings: 32'd1};
					beacon_new_total++;
					res.slot     = 4'(free_at);
					res.inserted = 1'b1;
				end
				// table full: drop, nothing changes
			end
			OP_FIND: begin
				if (hit_at >= 0) begin
					res.hit  = 1'b1;
					res.slot = 4'(hit_at);
				end
			end
			OP_CLEAR: begin
				res.slot = r.slot_index;
				if (beacon_used[r.slot_index]) begin
					res.hit = 1'b1;
					if (beacon_new[r.slot_index]) begin
						beacon_new[r.slot_index] = 1'b0;
						beacon_new_total--;
					end
				end
			end
			default: begin
				res.hit       = beacon_used[r.slot_index];
				res.slot      = r.slot_index;
				res.entry_new = beacon_new[r.slot_index];
				res.entry     = beacon_entry[r.slot_index];
			end
		endcase
		res.new_count = beacon_new_total;
		return res;
	endfunction

	function automatic req_t mk_req(op_t op, logic [47:0] a, logic [15:0] e, logic [15:0] d,
			logic signed [7:0] s, logic [31:0] t, logic [3:0] idx);
		req_t r;
		r.operation       = op;
		r.beacon_address  = a;
		r.environment_tag = e;
		r.device_tag      = d;
		r.signal_strength = s;
		r.now_ms          = t;
		r.slot_index      = idx;
		return r;
	endfunction

	function automatic result_t mk_res(logic h, logic [3:0] s, logic ins, logic [4:0] cnt);
		result_t res;
		res = '0;
		res.hit       = h;
		res.slot      = s;
		res.inserted  = ins;
		res.new_count = cnt;
		return res;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		int   k;
		r.beacon_address  = 48'({$urandom(), $urandom()});
		r.environment_tag = 16'($urandom());
		r.device_tag      = 16'($urandom());
		r.signal_strength = 8'($urandom());
		r.now_ms          = $urandom();
		r.slot_index      = 4'($urandom());
		// mostly known addresses, some near misses, some fresh ones
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, ENTRY_COUNT - 1);
		if (pick < 70 && beacon_used[k])
			r.beacon_address = beacon_entry[k].address;
		else if (pick < 85 && beacon_used[k])
			r.beacon_address = beacon_entry[k].address ^ (48'd1 << $urandom_range(0, 47));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.operation = OP_SIGHT;
		else if (pick < 60)
			r.operation = OP_FIND;
		else if (pick < 75)
			r.operation = OP_CLEAR;
		else
			r.operation = OP_READ;
		return r;
	endfunction

	task automatic add_row(req_t r, bit typed, result_t want);
		script.push_back('{req: r, typed: typed, want: want});
	endtask

	task automatic send_request(req_t r, bit typed, result_t want, bit drain);
		result_t predicted;
		if (drain) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (expected_q.size() != 0) @(posedge clk);
		end else if (!calm && $urandom_range(1, 100) <= send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= r.operation;
		beacon_address  <= r.beacon_address;
		environment_tag <= r.environment_tag;
		device_tag      <= r.device_tag;
		signal_strength <= r.signal_strength;
		now_ms          <= r.now_ms;
		slot_index      <= r.slot_index;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = registry_outcome(r);
		expected_q.push_back(typed ? want : predicted);
	endtask

	task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: transaction with no expected result, slot %0d hit %0b",
					$time, slot, hit);
			end else begin
				want = expected_q.pop_front();
				compare_field("hit", want.hit, hit);
				compare_field("slot", want.slot, slot);
				compare_field("inserted", want.inserted, inserted);
				compare_field("new_count", want.new_count, new_count);
				compare_field("entry_new", want.entry_new, entry_new);
				compare_field("entry_address", want.entry.address, entry_address);
				compare_field("entry_environment", want.entry.environment, entry_environment);
				compare_field("entry_device", want.entry.device, entry_device);
				compare_field("entry_strength", $unsigned(want.entry.strength),
					$unsigned(entry_strength));
				compare_field("entry_first_seen", want.entry.first_seen, entry_first_seen);
				compare_field("entry_last_seen", want.entry.last_seen, entry_last_seen);
				compare_field("entry_sightings", want.entry.sightings, entry_sightings);
			end
		end
	end

	// receiver: stall in bursts, and redraw the stall rate after each span of loop passes
	initial begin
		int stall_pct;
		int span;
		stall_pct = 0;
		span = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = 200;
				stall_pct = 10 * $urandom_range(0, 3);
			end
			span--;
			if (!calm && $urandom_range(1, 100) <= stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		result_t none;
		result_t full_read;
		logic [47:0] ones;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		operation       <= OP_SIGHT;
		beacon_address  <= '0;
		environment_tag <= '0;
		device_tag      <= '0;
		signal_strength <= '0;
		now_ms          <= '0;
		slot_index      <= '0;
		none = '0;
		ones = '1;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			beacon_entry[i] = '0;
			beacon_used[i]  = 1'b0;
			beacon_new[i]   = 1'b0;
		end
		beacon_new_total = '0;

		full_read = mk_res(1'b1, 4'd1, 1'b0, 5'd2);
		full_read.entry_new = 1'b1;
		full_read.entry = '{address: ones, environment: 16'hFFFF, device: 16'hFFFF,
			strength: 8'sd127, first_seen: 32'hFFFF_FFFF, last_seen: 32'hFFFF_FFFF,
			sightings: 32'd1};

		// empty table: read, miss, clear of an unused slot
		add_row(mk_req(OP_READ, '0, '0, '0, '0, '0, 4'd0), 1'b1, mk_res(0, 0, 0, 0));
		add_row(mk_req(OP_FIND, '0, '0, '0, '0, '0, 4'd0), 1'b1, mk_res(0, 0, 0, 0));
		add_row(mk_req(OP_CLEAR, '0, '0, '0, '0, '0, 4'd3), 1'b1, mk_res(0, 3, 0, 0));
		// inserts at both field extremes
		add_row(mk_req(OP_SIGHT, '0, '0, '0, 8'sh80, '0, 4'd0), 1'b1, mk_res(0, 0, 1, 1));
		add_row(mk_req(OP_SIGHT, ones, '1, '1, 8'sd127, '1, 4'hF), 1'b1, mk_res(0, 1, 1, 2));
		add_row(mk_req(OP_READ, '0, '0, '0, '0, '0, 4'd1), 1'b1, full_read);
		// update keeps identifiers, advances count
		add_row(mk_req(OP_SIGHT, '0, '1, '1, 8'sd127, 32'd12345, 4'd0), 1'b1,
			mk_res(1, 0, 0, 2));
		add_row(mk_req(OP_READ, '0, '0, '0, '0, '0, 4'd0), 1'b0, none);
		add_row(mk_req(OP_FIND, ones, '0, '0, '0, '0, 4'd0), 1'b1, mk_res(1, 1, 0, 2));
		add_row(mk_req(OP_CLEAR, '0, '0, '0, '0, '0, 4'd0), 1'b1, mk_res(1, 0, 0, 1));
		add_row(mk_req(OP_CLEAR, '0, '0, '0, '0, '0, 4'd0), 1'b0, none);
		// fill the rest of the table
		for (int i = 2; i < ENTRY_COUNT; i++)
			add_row(mk_req(OP_SIGHT, 48'h0123_4567_89A0 + 48'(i), 16'h1000 + 16'(i),
				16'h2000 + 16'(i), 8'(-i), 32'(i * 1000), 4'(i)), 1'b0, none);
		// table full: dropped
		add_row(mk_req(OP_SIGHT, 48'hC0FF_EE00_0000, '1, '1, '0, '1, 4'd0), 1'b1,
			mk_res(0, 0, 0, 15));
		add_row(mk_req(OP_READ, '0, '0, '0, '0, '0, 4'(ENTRY_COUNT - 1)), 1'b0, none);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_request(script[i].req, script[i].typed, script[i].want, 1'b0);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				send_idle_pct = 15 * $urandom_range(0, 2);
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_request(random_request(), 1'b0, none, n == RANDOM_ITEMS / 3);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/bar_pkg.sv
sv/bar_entry_ram.sv
sv/bar_ctrl.sv
sv/beacon_address_registry_unit.sv
sv/bar_checker.sv
sim/tb_top.sv
